// ===== src/kdbc_pkg.sv =====
// ----------------------------------------------------------------------------
// kdbc_pkg: shared types and constants for the key debouncer
// Item kinds, register indexes, reset values and the per-key event bundle.
// ----------------------------------------------------------------------------
package kdbc_pkg;

  localparam int unsigned MAX_KEYS  = 4;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned EVT_W     = 8;
  localparam int unsigned LONG_MSB  = 7;  // long flag of key k is bit LONG_MSB-k
  localparam int unsigned CLICK_MSB = 3;  // click flag of key k is bit CLICK_MSB-k

  localparam logic [TICK_W-1:0] DEBOUNCE_RST   = 8'd3;
  localparam logic [TICK_W-1:0] LONG_PRESS_RST = 8'd20;

  localparam logic [EVT_W-1:0] LONG_NIBBLE = 8'hF0;

  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic CFG_IDX_DEBOUNCE   = 1'b0;
  localparam logic CFG_IDX_LONG_PRESS = 1'b1;

  typedef struct packed {
    logic set_long;
    logic clr_long;
    logic set_click;
  } kdbc_evt_t;

  typedef struct packed {
    logic [TICK_W-1:0] debounce;
    logic [TICK_W-1:0] long_press;
  } kdbc_cfg_t;

  // Event bits that can ever be set for a given key count.
  function automatic logic [EVT_W-1:0] evt_mask(input int unsigned n);
    logic [EVT_W-1:0] m;
    m = '0;
    for (int unsigned k = 0; k < MAX_KEYS; k++) begin
      if (k < n) begin
        m[LONG_MSB-k]  = 1'b1;
        m[CLICK_MSB-k] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

// ===== src/kdbc_lane.sv =====
// ----------------------------------------------------------------------------
// kdbc_lane: one key's debouncer
// Four-phase press/release debouncer; one tick counter also times long press.
// ----------------------------------------------------------------------------
module kdbc_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,     // scan tick accepted
  input  logic               pressed_i,
  input  logic               long_i,     // current long flag of this key
  input  kdbc_pkg::kdbc_cfg_t cfg_i,
  output kdbc_pkg::kdbc_evt_t evt_o
);
  import kdbc_pkg::*;

  typedef enum logic [1:0] {
    REL_STABLE = 2'd0,
    PRS_BOUNCE = 2'd1,
    PRS_STABLE = 2'd2,
    REL_BOUNCE = 2'd3
  } key_phase_e;

  key_phase_e        phase_q, phase_d;
  logic [TICK_W-1:0] ticks_q, ticks_d, ticks_inc;
  kdbc_evt_t         evt;

  // saturating increment
  assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + TICK_W'(1);

  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    evt     = '0;
    case (phase_q)
      REL_STABLE: begin
        if (pressed_i) begin
          phase_d = PRS_BOUNCE;
          ticks_d = '0;
        end
      end
      PRS_BOUNCE: begin
        if (pressed_i) begin
          ticks_d = ticks_inc;
          if (ticks_inc >= cfg_i.debounce) begin
            phase_d = PRS_STABLE;
            ticks_d = '0;
          end
        end else begin
          phase_d = REL_STABLE;
          ticks_d = '0;
        end
      end
      PRS_STABLE: begin
        if (pressed_i) begin
          ticks_d = ticks_inc;
          if (ticks_inc >= cfg_i.long_press) begin
            evt.set_long = 1'b1;
            ticks_d      = '0;
          end
        end else begin
          phase_d = REL_BOUNCE;
          ticks_d = '0;
        end
      end
      default: begin
        if (pressed_i) begin
          phase_d = PRS_STABLE;
          ticks_d = '0;
        end else begin
          ticks_d = ticks_inc;
          if (ticks_inc >= cfg_i.debounce) begin
            phase_d = REL_STABLE;
            ticks_d = '0;
            // a release after a long press consumes the long flag
            if (long_i) evt.clr_long  = 1'b1;
            else        evt.set_click = 1'b1;
          end
        end
      end
    endcase
  end

  assign evt_o = step_i ? evt : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= REL_STABLE;
      ticks_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

// ===== src/kdbc_merge.sv =====
// ----------------------------------------------------------------------------
// kdbc_merge: event byte merge
// Folds lane events into the pending event byte; serves reads and click clear.
// ----------------------------------------------------------------------------
module kdbc_merge #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         kind_i,
  input  kdbc_pkg::kdbc_evt_t          evt_i [NUM_KEYS],
  output logic [NUM_KEYS-1:0]          long_o,
  output logic [kdbc_pkg::EVT_W-1:0]   result_o
);
  import kdbc_pkg::*;

  logic [EVT_W-1:0] pending_q, pending_d, scan_byte;

  always_comb begin
    scan_byte = pending_q;
    for (int unsigned k = 0; k < NUM_KEYS; k++) begin
      if (evt_i[k].set_long)  scan_byte[LONG_MSB-k]  = 1'b1;
      if (evt_i[k].clr_long)  scan_byte[LONG_MSB-k]  = 1'b0;
      if (evt_i[k].set_click) scan_byte[CLICK_MSB-k] = 1'b1;
    end
  end

  always_comb begin
    for (int unsigned k = 0; k < NUM_KEYS; k++) begin
      long_o[k] = pending_q[LONG_MSB-k];
    end
  end

  // read returns the byte before clearing; scan returns the updated byte
  assign result_o  = (kind_i == KIND_READ) ? pending_q : scan_byte;
  assign pending_d = (kind_i == KIND_READ) ? (pending_q & LONG_NIBBLE) : scan_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (accept_i) begin
      pending_q <= pending_d;
    end
  end

endmodule

// ===== src/key_debounce_click_longpress.sv =====
// ----------------------------------------------------------------------------
// key_debounce_click_longpress: four-key debouncer with click and long press
// Per-key debounce lanes, an event byte merge and a two-entry output buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): each item is either a scan tick
//   (kind_i = 0) carrying raw active-low key levels, or a read (kind_i = 1)
//   that returns the event byte and clears the click nibble.
//   Output channel (out_valid_o/out_ready_i): exactly one item per input
//   item, in order: event_flags_o, bits 7..4 long press of keys 0..3,
//   bits 3..0 click of keys 0..3.
//   Throughput: one item per cycle while in_ready_o is high. All key
//   lanes step in parallel in the accept cycle; only a full buffer stalls.
//   Stall: results go into a two-entry buffer (output register plus skid
//   register). in_ready_o is registered and drops only when both entries
//   hold results, so one more item is taken while a result waits.
//   Reset: all keys released-stable, counters and event byte zero,
//   debounce_ticks = 3, long_press_ticks = 20.
//   Configuration: cfg_we_i writes register cfg_addr_i (0 debounce_ticks,
//   1 long_press_ticks) at once; write only while the block is idle.
// ----------------------------------------------------------------------------
module key_debounce_click_longpress #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_addr_i,
  input  logic [7:0] cfg_wdata_i,
  // input items
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [3:0] key_levels_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] event_flags_o
);
  import kdbc_pkg::*;

  localparam logic [EVT_W-1:0] EVT_MASK = evt_mask(NUM_KEYS);

  kdbc_cfg_t           cfg_q;
  logic                accept;
  logic                scan_step;
  kdbc_evt_t           evt [NUM_KEYS];
  logic [NUM_KEYS-1:0] long_flags;
  logic [EVT_W-1:0]    result;

  logic                out_vld_q, skid_vld_q;
  logic [EVT_W-1:0]    out_data_q, skid_data_q;

  assign in_ready_o = !skid_vld_q;
  assign accept     = in_valid_i && in_ready_o;
  assign scan_step  = accept && (kind_i == KIND_SCAN);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce   <= DEBOUNCE_RST;
      cfg_q.long_press <= LONG_PRESS_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_IDX_DEBOUNCE:   cfg_q.debounce   <= cfg_wdata_i;
        CFG_IDX_LONG_PRESS: cfg_q.long_press <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // One debounce lane per key; the level bit is active low
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kdbc_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (scan_step),
      .pressed_i (!key_levels_i[k]),
      .long_i    (long_flags[k]),
      .cfg_i     (cfg_q),
      .evt_o     (evt[k])
    );
  end

  // Lane events fold into the pending byte
  kdbc_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .kind_i   (kind_i),
    .evt_i    (evt),
    .long_o   (long_flags),
    .result_o (result)
  );

  // Output register with skid entry. When the skid entry is full no item is
  // accepted, so it drains into the output register first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= accept;
      end
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_ready_i) begin
      if (skid_vld_q) begin
        out_data_q <= skid_data_q;
      end else if (accept) begin
        out_data_q <= result;
      end
    end else if (accept) begin
      skid_data_q <= result;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign event_flags_o = out_data_q;

  // Skid entry is only ever filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid without output entry");

  // An item taken while the output stalls must land in the skid entry
  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && out_vld_q && !out_ready_i) |=> skid_vld_q)
    else $error("item accepted under stall was lost");

  // Keys beyond NUM_KEYS never report events
  a_unused_keys_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((event_flags_o & ~EVT_MASK) == '0))
    else $error("event bit set for a key that does not exist");

endmodule

// ===== test/key_debounce_click_longpress_test.sv =====
// ----------------------------------------------------------------------------
// key_debounce_click_longpress_test: self-checking bench for the key debouncer
// Drives scan and read items through the valid/ready input, predicts every
// event byte with an in-bench copy of the four key machines, and checks the
// result stream in order under random idling, a long output stall and
// register changes that include both extremes and a zero setting.
// ----------------------------------------------------------------------------
module key_debounce_click_longpress_test;

  timeunit 1ns;
  timeprecision 1ps;

  import kdbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no item accepted or delivered
  localparam int DRAIN_EXTRA    = 3;     // margin after the last result is taken
  localparam int ITEMS_PER_MIX  = 255;
  localparam int MAX_REPORTS    = 20;

  typedef enum logic [1:0] {
    PH_REL_STABLE = 2'd0,
    PH_PRS_BOUNCE = 2'd1,
    PH_PRS_STABLE = 2'd2,
    PH_REL_BOUNCE = 2'd3
  } key_phase_e;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic       cfg_addr;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic       kind;
  logic [3:0] key_levels;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] event_flags;

  key_debounce_click_longpress u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (kind),
    .key_levels_i (key_levels),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .event_flags_o(event_flags)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Event byte predictor: own copy of the key machines and the two registers.
  // --------------------------------------------------------------------------
  key_phase_e       key_phase_q [MAX_KEYS];
  logic [TICK_W-1:0] key_count_q [MAX_KEYS];
  logic [EVT_W-1:0]  events_q;
  logic [TICK_W-1:0] cfg_debounce;
  logic [TICK_W-1:0] cfg_long_press;

  logic [EVT_W-1:0] expected_flags [$];

  int mismatch_count;
  int scan_count;
  int read_count;
  int click_count;
  int long_count;

  // Counter after one saturating increment.
  function automatic logic [TICK_W-1:0] bump(input logic [TICK_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Applies one item to the predictor state and returns the byte the block
  // must hand back for it.
  function automatic logic [EVT_W-1:0] next_event_flags(input logic       k_kind,
                                                        input logic [3:0] levels);
    logic [EVT_W-1:0] flags;
    logic             down;
    int               long_bit;
    int               click_bit;
    if (k_kind == KIND_READ) begin
      // read returns the byte first, then drops the clicks
      flags    = events_q;
      events_q = events_q & LONG_NIBBLE;
      read_count++;
      return flags;
    end
    scan_count++;
    for (int k = 0; k < MAX_KEYS; k++) begin
      down      = ~levels[k];  // active-low key port
      long_bit  = LONG_MSB - k;
      click_bit = CLICK_MSB - k;
      case (key_phase_q[k])
        PH_REL_STABLE: begin
          if (down) begin
            key_phase_q[k] = PH_PRS_BOUNCE;
            key_count_q[k] = '0;
          end
        end
        PH_PRS_BOUNCE: begin
          if (!down) begin
            // bounced back: start over from released with a fresh count
            key_phase_q[k] = PH_REL_STABLE;
            key_count_q[k] = '0;
          end else begin
            key_count_q[k] = bump(key_count_q[k]);
            if (key_count_q[k] >= cfg_debounce) begin
              key_phase_q[k] = PH_PRS_STABLE;
              key_count_q[k] = '0;
            end
          end
        end
        PH_PRS_STABLE: begin
          if (!down) begin
            key_phase_q[k] = PH_REL_BOUNCE;
            key_count_q[k] = '0;
          end else begin
            key_count_q[k] = bump(key_count_q[k]);
            if (key_count_q[k] >= cfg_long_press) begin
              if (!events_q[long_bit]) long_count++;
              events_q[long_bit] = 1'b1;
              key_count_q[k]     = '0;
            end
          end
        end
        default: begin
          if (down) begin
            key_phase_q[k] = PH_PRS_STABLE;
            key_count_q[k] = '0;
          end else begin
            key_count_q[k] = bump(key_count_q[k]);
            if (key_count_q[k] >= cfg_debounce) begin
              key_phase_q[k] = PH_REL_STABLE;
              key_count_q[k] = '0;
              // a release after a long press only retires the long flag
              if (events_q[long_bit]) begin
                events_q[long_bit] = 1'b0;
              end else begin
                if (!events_q[click_bit]) click_count++;
                events_q[click_bit] = 1'b1;
              end
            end
          end
        end
      endcase
    end
    return events_q;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking, receiver idling and the watchdog.
  // --------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  logic [EVT_W-1:0] want_flags;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (expected_flags.size() == 0) begin
        flag_error($sformatf("result %02h with no item outstanding", event_flags));
      end else begin
        want_flags = expected_flags.pop_front();
        if (event_flags !== want_flags)
          flag_error($sformatf("event_flags %02h, predicted %02h", event_flags, want_flags));
      end
    end
  end

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;  // long receiver hold-off, counted down below

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  int quiet_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[key_debounce_click_longpress] ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side. Every task starts on a falling edge; send_item returns on
  // the accepting rising edge with valid still high, so the next call either
  // replaces the payload or lowers valid with a single update.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic k_kind, input logic [3:0] levels);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    kind       <= k_kind;
    key_levels <= levels;
    do @(posedge clk_i); while (!in_ready);
    expected_flags.push_back(next_event_flags(k_kind, levels));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_flags.size() != 0) @(negedge clk_i);
    repeat (DRAIN_EXTRA) @(negedge clk_i);
  endtask

  // Only called with the block drained.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_DEBOUNCE) cfg_debounce = value;
    else                         cfg_long_press = value;
  endtask

  // Key activity model: each key holds its intended level for a random run,
  // with contact bounce right after each change.
  bit want_down [MAX_KEYS];
  int hold_left [MAX_KEYS];
  int since_change [MAX_KEYS];

  task automatic key_traffic(input logic [7:0] deb, input logic [7:0] lp,
                             input int items, input int s_idle, input int r_idle,
                             input bit noisy);
    logic [3:0] levels;
    int         span;
    bit         down;
    wait_drained();
    write_reg(CFG_IDX_DEBOUNCE, deb);
    write_reg(CFG_IDX_LONG_PRESS, lp);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    // runs long enough to reach several long presses, short enough to bounce out
    span = ((deb == 0) ? 1 : deb) + 2 * ((lp == 0) ? 1 : lp) + 4;
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(7) == 0) begin
        send_item(KIND_READ, 4'($urandom));
      end else begin
        if (noisy && $urandom_range(24) == 0) begin
          levels = 4'($urandom);
        end else begin
          for (int k = 0; k < MAX_KEYS; k++) begin
            if (hold_left[k] == 0) begin
              want_down[k]    = !want_down[k];
              hold_left[k]    = $urandom_range(span, 1);
              since_change[k] = 0;
            end
            hold_left[k]--;
            down = want_down[k];
            if (since_change[k] < 4 && $urandom_range(2) == 0) down = !down;
            since_change[k]++;
            levels[k] = !down;
          end
        end
        send_item(KIND_SCAN, levels);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked sequences: all keys long-pressed and released, a click with
  // read-and-clear, a press bounce that returns to release (its count must
  // restart), a release bounce that returns to press, and a zero register.
  task automatic test_click_and_long_press();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_IDX_DEBOUNCE, 8'd0);  // zero behaves as one
    write_reg(CFG_IDX_LONG_PRESS, 8'd2);
    repeat (4) send_item(KIND_SCAN, 4'h0);  // every key down, long flags set
    send_item(KIND_READ, 4'hF);            // clicks cleared, long flags kept
    repeat (2) send_item(KIND_SCAN, 4'hF); // releases retire long flags
    send_item(KIND_SCAN, 4'hE);            // key 0 click
    send_item(KIND_SCAN, 4'hE);
    send_item(KIND_SCAN, 4'hF);
    send_item(KIND_SCAN, 4'hF);
    send_item(KIND_READ, 4'h0);
    send_item(KIND_READ, 4'h5);            // click already gone
    wait_drained();
    write_reg(CFG_IDX_DEBOUNCE, 8'd2);
    send_item(KIND_SCAN, 4'h7);            // key 3 starts bouncing
    send_item(KIND_SCAN, 4'h7);
    send_item(KIND_SCAN, 4'hF);            // back to released, count cleared
    send_item(KIND_SCAN, 4'h7);
    send_item(KIND_SCAN, 4'h7);            // still bouncing if the count restarted
    send_item(KIND_SCAN, 4'h7);
    send_item(KIND_SCAN, 4'hF);            // release bounce...
    send_item(KIND_SCAN, 4'h7);            // ...returns to press
    repeat (3) send_item(KIND_SCAN, 4'hF);
    send_item(KIND_READ, 4'hA);
  endtask

  task automatic test_sparse_sender();
    key_traffic(8'd1, 8'd4, ITEMS_PER_MIX, 12, 58, 1'b1);
    key_traffic(DEBOUNCE_RST, LONG_PRESS_RST, ITEMS_PER_MIX, 12, 58, 1'b0);
  endtask

  task automatic test_sparse_receiver();
    key_traffic(8'd2, 8'd1, ITEMS_PER_MIX, 58, 12, 1'b1);
    key_traffic(8'd255, 8'd3, ITEMS_PER_MIX, 58, 12, 1'b0);
  endtask

  task automatic test_full_rate();
    key_traffic(8'd1, 8'd255, ITEMS_PER_MIX, 0, 0, 1'b0);
    key_traffic(8'd0, 8'd0, ITEMS_PER_MIX, 0, 0, 1'b1);
    key_traffic(8'd4, 8'd6, ITEMS_PER_MIX, 0, 0, 1'b1);
  endtask

  // Receiver blocked for a long stretch while items keep coming, so the
  // output buffer fills and the input stalls; then the sender waits for
  // every result before the next burst.
  task automatic test_backpressure();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 40;
    repeat (16) send_item($urandom_range(3) == 0 ? KIND_READ : KIND_SCAN, 4'($urandom));
    wait_drained();
    repeat (12) send_item($urandom_range(3) == 0 ? KIND_READ : KIND_SCAN, 4'($urandom));
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = CFG_IDX_DEBOUNCE;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    kind           = KIND_SCAN;
    key_levels     = 4'hF;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_cycles    = 0;
    quiet_cycles   = 0;
    mismatch_count = 0;
    scan_count     = 0;
    read_count     = 0;
    click_count    = 0;
    long_count     = 0;
    cfg_debounce   = DEBOUNCE_RST;
    cfg_long_press = LONG_PRESS_RST;
    events_q       = '0;
    for (int k = 0; k < MAX_KEYS; k++) begin
      key_phase_q[k]  = PH_REL_STABLE;
      key_count_q[k]  = '0;
      want_down[k]    = 1'b0;
      hold_left[k]    = 0;
      since_change[k] = 0;
    end
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_click_and_long_press();
    test_sparse_sender();
    test_sparse_receiver();
    test_backpressure();
    test_full_rate();
    wait_drained();

    $display("Ran %0d scan and %0d read items across nine register settings,",
             scan_count, read_count);
    $display("with %0d clicks, %0d long presses and a 40-cycle output stall; %0d mismatches.",
             click_count, long_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[key_debounce_click_longpress] OK");
    end else begin
      $display("[key_debounce_click_longpress] ERROR");
    end
    $finish;
  end

endmodule
